// File: rtl/lru_write_back_block_cache_control_macros.svh
// Assertion macros for the block cache control RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef LRU_WRITE_BACK_BLOCK_CACHE_CONTROL_MACROS_SVH
`define LRU_WRITE_BACK_BLOCK_CACHE_CONTROL_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define LWBC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define LWBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LWBC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LWBC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/lwbc_pkg.sv
// Shared types, codes and constants for the block cache control block.
// No dependencies.
package lwbc_pkg;

    localparam int NUM_SLOTS_DEF = 16;

    localparam int BNO_W   = 32;
    localparam int STAMP_W = 32;
    localparam int SLOT_W  = 6;
    localparam int BS_W    = 17;
    localparam int ADDR_W  = 48;

    localparam logic [BS_W-1:0] BLOCK_SIZE_RESET = 17'd4096;
    localparam logic [BS_W-1:0] BLOCK_SIZE_MAX   = 17'd65536;

    localparam logic [1:0] ACT_ACCESS = 2'd0;
    localparam logic [1:0] ACT_MARK   = 2'd1;
    localparam logic [1:0] ACT_WB     = 2'd2;
    localparam logic [1:0] ACT_FLUSH  = 2'd3;

    localparam logic [2:0] KIND_HIT    = 3'd0;
    localparam logic [2:0] KIND_WB     = 3'd1;
    localparam logic [2:0] KIND_FILL   = 3'd2;
    localparam logic [2:0] KIND_DONE   = 3'd3;
    localparam logic [2:0] KIND_ABSENT = 3'd4;
    localparam logic [2:0] KIND_REJECT = 3'd5;

    typedef logic [SLOT_W-1:0] slot_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [BNO_W-1:0] block_number;
        logic             is_write;
    } item_t;

    typedef struct packed {
        logic [2:0]        kind;
        slot_t             slot;
        logic [BNO_W-1:0]  block_addr;
        logic [ADDR_W-1:0] mem_address;
        logic              last;
    } result_t;

    // Search packet travelling down the slot chain.
    typedef struct packed {
        logic               valid;
        logic               flush;
        logic [BNO_W-1:0]   bno;
        logic               found;
        slot_t              found_idx;
        logic               found_dirty;
        logic               have_empty;
        slot_t              empty_idx;
        logic               have_min;
        logic [STAMP_W-1:0] min_stamp;
        slot_t              min_idx;
        logic [BNO_W-1:0]   min_tag;
        logic               min_dirty;
        logic               wb_hit;
        slot_t              wb_idx;
        logic [BNO_W-1:0]   wb_tag;
    } scan_t;

    // Slot update broadcast from the controller.
    typedef struct packed {
        logic               valid;
        slot_t              slot;
        logic               write_tag;
        logic [BNO_W-1:0]   tag;
        logic               write_stamp;
        logic [STAMP_W-1:0] stamp;
        logic               dirty_clr;
        logic               dirty_set;
    } upd_t;

    // Result request into the output stage.
    typedef struct packed {
        logic             valid;
        logic [2:0]       kind;
        slot_t            slot;
        logic [BNO_W-1:0] block_addr;
        logic             use_mul;
        logic             last;
    } emit_t;

endpackage

// File: rtl/lwbc_cell.sv
// One cache slot: tag, stamp and dirty bit, plus one stage of the search chain.
// Depends on lwbc_pkg.
module lwbc_cell #(
    parameter int IDX = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  lwbc_pkg::scan_t pkt_in,
    input  lwbc_pkg::upd_t  upd,
    output lwbc_pkg::scan_t pkt_out
);
    import lwbc_pkg::*;

    localparam slot_t MY_IDX = SLOT_W'(IDX);

    logic [BNO_W-1:0]   tag_reg, tag_next;
    logic [STAMP_W-1:0] stamp_reg, stamp_next;
    logic               dirty_reg, dirty_next;
    logic               pkt_valid_reg;
    scan_t              pkt_reg, pkt_next;

    always_comb
    begin
        pkt_next        = pkt_in;
        pkt_next.wb_hit = 1'b0;
        if (pkt_in.flush)
        begin
            if (dirty_reg)
            begin
                pkt_next.wb_hit = 1'b1;
                pkt_next.wb_idx = MY_IDX;
                pkt_next.wb_tag = tag_reg;
            end
        end
        else
        begin
            if (!pkt_in.found && tag_reg == pkt_in.bno)
            begin
                pkt_next.found       = 1'b1;
                pkt_next.found_idx   = MY_IDX;
                pkt_next.found_dirty = dirty_reg;
            end
            if (!pkt_in.have_empty && tag_reg == '0)
            begin
                pkt_next.have_empty = 1'b1;
                pkt_next.empty_idx  = MY_IDX;
            end
            // strict compare keeps the first slot among equal stamps
            if (!pkt_in.have_min || stamp_reg < pkt_in.min_stamp)
            begin
                pkt_next.have_min  = 1'b1;
                pkt_next.min_stamp = stamp_reg;
                pkt_next.min_idx   = MY_IDX;
                pkt_next.min_tag   = tag_reg;
                pkt_next.min_dirty = dirty_reg;
            end
        end
    end

    always_comb
    begin
        tag_next   = tag_reg;
        stamp_next = stamp_reg;
        dirty_next = dirty_reg;
        if (pkt_in.valid && pkt_in.flush)
        begin
            dirty_next = 1'b0;
        end
        if (upd.valid && upd.slot == MY_IDX)
        begin
            if (upd.write_tag)
            begin
                tag_next = upd.tag;
            end
            if (upd.write_stamp)
            begin
                stamp_next = upd.stamp;
            end
            dirty_next = (dirty_reg && !upd.dirty_clr) || upd.dirty_set;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg       <= '0;
            stamp_reg     <= '0;
            dirty_reg     <= 1'b0;
            pkt_valid_reg <= 1'b0;
        end
        else
        begin
            tag_reg       <= tag_next;
            stamp_reg     <= stamp_next;
            dirty_reg     <= dirty_next;
            pkt_valid_reg <= pkt_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt_in.valid)
        begin
            pkt_reg <= pkt_next;
        end
    end

    always_comb
    begin
        pkt_out       = pkt_reg;
        pkt_out.valid = pkt_valid_reg;
    end

endmodule

// File: rtl/lwbc_result.sv
// Output stage: request register, block size scaling multiply, result register.
// Depends on lwbc_pkg.
module lwbc_result (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [lwbc_pkg::BS_W-1:0]    block_size,
    input  lwbc_pkg::emit_t              req,
    output lwbc_pkg::result_t            result,
    output logic                         result_valid
);
    import lwbc_pkg::*;

    emit_t                  req_reg;
    logic                   req_valid_reg;
    logic [BS_W-1:0]        bs_eff;
    logic [BNO_W+BS_W-1:0]  product;
    result_t                result_reg, result_next;
    logic                   result_valid_reg;

    always_comb
    begin
        if (block_size == '0)
        begin
            bs_eff = BS_W'(1);
        end
        else if (block_size > BLOCK_SIZE_MAX)
        begin
            bs_eff = BLOCK_SIZE_MAX;
        end
        else
        begin
            bs_eff = block_size;
        end
        product = (BNO_W+BS_W)'(req_reg.block_addr) * (BNO_W+BS_W)'(bs_eff);

        result_next.kind        = req_reg.kind;
        result_next.slot        = req_reg.slot;
        result_next.block_addr  = req_reg.block_addr;
        result_next.mem_address = req_reg.use_mul ? product[ADDR_W-1:0] : '0;
        result_next.last        = req_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg    <= req.valid;
            result_valid_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            req_reg <= req;
        end
        if (req_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

// File: rtl/lru_write_back_block_cache_control.sv
// Top level: command sequencer, slot chain and output stage of the block cache control.
// Depends on lwbc_pkg, lwbc_cell, lwbc_result and the assertion macro header.
// Timing: a search result passes the slot chain, then the request and result registers of
// the output stage; rejects skip the chain. Flush write-backs leave as the packet passes each dirty slot.
// A new item is taken only when idle (busy low): one search packet walks the chain, one cell a cycle;
// a dirty-victim miss adds the fill state, a flush the flush-end state; a reject leaves it idle.
// Reset: all slots empty, stamps, dirty bits and use counter zero, block size 4096.
`include "lru_write_back_block_cache_control_macros.svh"
module lru_write_back_block_cache_control #(
    parameter int NUM_SLOTS = lwbc_pkg::NUM_SLOTS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  lwbc_pkg::item_t           item,
    output lwbc_pkg::result_t         result,
    output logic                      result_valid,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [lwbc_pkg::BS_W-1:0] cfg_data
);
    import lwbc_pkg::*;

    localparam logic [1:0] ST_IDLE      = 2'd0;
    localparam logic [1:0] ST_SCAN      = 2'd1;
    localparam logic [1:0] ST_FILL      = 2'd2;
    localparam logic [1:0] ST_FLUSH_END = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [1:0]         act_reg, act_next;
    logic [BNO_W-1:0]   bno_reg, bno_next;
    logic               wr_reg, wr_next;
    slot_t              victim_reg, victim_next;
    logic [STAMP_W-1:0] counter_reg, counter_next;
    logic [BS_W-1:0]    block_size_reg;

    scan_t pkt [0:NUM_SLOTS];
    upd_t  upd;
    emit_t emit;
    logic  accept;
    logic  tap_hit;
    slot_t tap_idx;
    logic [BNO_W-1:0] tap_tag;
    scan_t end_pkt;
    slot_t victim;

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign end_pkt   = pkt[NUM_SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= BLOCK_SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            block_size_reg <= cfg_data;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < NUM_SLOTS; gi++)
        begin : g_cell
            lwbc_cell #(
                .IDX(gi)
            ) u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .pkt_in (pkt[gi]),
                .upd    (upd),
                .pkt_out(pkt[gi+1])
            );
        end
    endgenerate

    // Only one packet is in the chain, so at most one cell reports a flush write-back.
    always_comb
    begin
        tap_hit = 1'b0;
        tap_idx = '0;
        tap_tag = '0;
        for (int i = 1; i <= NUM_SLOTS; i++)
        begin
            if (pkt[i].valid && pkt[i].flush && pkt[i].wb_hit)
            begin
                tap_hit = 1'b1;
                tap_idx = pkt[i].wb_idx;
                tap_tag = pkt[i].wb_tag;
            end
        end
    end

    assign victim = end_pkt.have_empty ? end_pkt.empty_idx : end_pkt.min_idx;

    always_comb
    begin
        state_next   = state_reg;
        act_next     = act_reg;
        bno_next     = bno_reg;
        wr_next      = wr_reg;
        victim_next  = victim_reg;
        counter_next = counter_reg;

        pkt[0]       = '0;
        upd          = '0;
        emit         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    act_next = item.action;
                    bno_next = item.block_number;
                    wr_next  = item.is_write;
                    if (item.action == ACT_FLUSH)
                    begin
                        pkt[0].valid = 1'b1;
                        pkt[0].flush = 1'b1;
                        state_next   = ST_SCAN;
                    end
                    else if (item.block_number == '0)
                    begin
                        emit.valid = 1'b1;
                        emit.kind  = KIND_REJECT;
                        emit.last  = 1'b1;
                    end
                    else
                    begin
                        pkt[0].valid = 1'b1;
                        pkt[0].bno   = item.block_number;
                        if (item.action == ACT_ACCESS)
                        begin
                            counter_next = counter_reg + STAMP_W'(1);
                        end
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (tap_hit)
                begin
                    emit.valid      = 1'b1;
                    emit.kind       = KIND_WB;
                    emit.slot       = tap_idx;
                    emit.block_addr = tap_tag;
                    emit.use_mul    = 1'b1;
                end
                if (end_pkt.valid)
                begin
                    if (act_reg == ACT_FLUSH)
                    begin
                        state_next = ST_FLUSH_END;
                    end
                    else
                    begin
                        state_next      = ST_IDLE;
                        emit.valid      = 1'b1;
                        emit.last       = 1'b1;
                        emit.block_addr = bno_reg;
                        upd.slot        = end_pkt.found_idx;
                        case (act_reg)
                            ACT_ACCESS:
                            begin
                                upd.valid       = 1'b1;
                                upd.write_stamp = 1'b1;
                                upd.stamp       = counter_reg;
                                upd.dirty_set   = wr_reg;
                                emit.use_mul    = 1'b1;
                                if (end_pkt.found)
                                begin
                                    emit.kind = KIND_HIT;
                                    emit.slot = end_pkt.found_idx;
                                end
                                else
                                begin
                                    upd.slot      = victim;
                                    upd.write_tag = 1'b1;
                                    upd.tag       = bno_reg;
                                    upd.dirty_clr = 1'b1;
                                    victim_next   = victim;
                                    if (!end_pkt.have_empty && end_pkt.min_dirty)
                                    begin
                                        // dirty victim goes out first, fill follows
                                        emit.kind       = KIND_WB;
                                        emit.slot       = victim;
                                        emit.block_addr = end_pkt.min_tag;
                                        emit.last       = 1'b0;
                                        state_next      = ST_FILL;
                                    end
                                    else
                                    begin
                                        emit.kind = KIND_FILL;
                                        emit.slot = victim;
                                    end
                                end
                            end
                            ACT_MARK:
                            begin
                                if (end_pkt.found)
                                begin
                                    upd.valid     = 1'b1;
                                    upd.dirty_set = 1'b1;
                                    emit.kind     = KIND_DONE;
                                    emit.slot     = end_pkt.found_idx;
                                end
                                else
                                begin
                                    emit.kind = KIND_ABSENT;
                                end
                            end
                            default:
                            begin
                                if (!end_pkt.found)
                                begin
                                    emit.kind = KIND_ABSENT;
                                end
                                else if (end_pkt.found_dirty)
                                begin
                                    upd.valid     = 1'b1;
                                    upd.dirty_clr = 1'b1;
                                    emit.kind     = KIND_WB;
                                    emit.slot     = end_pkt.found_idx;
                                    emit.use_mul  = 1'b1;
                                end
                                else
                                begin
                                    emit.kind = KIND_DONE;
                                    emit.slot = end_pkt.found_idx;
                                end
                            end
                        endcase
                    end
                end
            end

            ST_FILL:
            begin
                emit.valid      = 1'b1;
                emit.kind       = KIND_FILL;
                emit.slot       = victim_reg;
                emit.block_addr = bno_reg;
                emit.use_mul    = 1'b1;
                emit.last       = 1'b1;
                state_next      = ST_IDLE;
            end

            ST_FLUSH_END:
            begin
                emit.valid = 1'b1;
                emit.kind  = KIND_DONE;
                emit.last  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            counter_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            counter_reg <= counter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        bno_reg    <= bno_next;
        wr_reg     <= wr_next;
        victim_reg <= victim_next;
    end

    lwbc_result u_result (
        .clk         (clk),
        .rst_n       (rst_n),
        .block_size  (block_size_reg),
        .req         (emit),
        .result      (result),
        .result_valid(result_valid)
    );

    `LWBC_ASSERT_IMP(a_idle_chain_empty, clk, rst_n, state_reg == ST_IDLE, !end_pkt.valid)
    `LWBC_ASSERT_IMP(a_tap_only_flush, clk, rst_n, end_pkt.valid && !end_pkt.flush, !tap_hit)
    `LWBC_ASSERT_NEXT(a_flush_busy, clk, rst_n, accept && item.action == ACT_FLUSH, busy)

endmodule

// File: verif/lwbc_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the block cache control: watches the command, config and result ports.
// Predicts each transaction's results in order and compares them. Depends on lwbc_pkg.
module lwbc_checker #(
    parameter int NUM_SLOTS = lwbc_pkg::NUM_SLOTS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  lwbc_pkg::item_t           item,
    input  lwbc_pkg::result_t         result,
    input  logic                      result_valid,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [lwbc_pkg::BS_W-1:0] cfg_data,
    output int                        open_cnt,
    output int                        errors
);
    import lwbc_pkg::*;

    localparam int MAX_REPORTS = 10;

    logic [BNO_W-1:0]   tags   [NUM_SLOTS];
    logic [STAMP_W-1:0] stamps [NUM_SLOTS];
    logic               dirty  [NUM_SLOTS];
    logic [STAMP_W-1:0] use_cnt;
    logic [BS_W-1:0]    blk_size;

    result_t pending_results [$];
    int      mismatches;

    function automatic logic [ADDR_W-1:0] byte_address(input logic [BNO_W-1:0] bno);
        logic [ADDR_W-1:0] bs;
        bs = ADDR_W'(blk_size);
        if (bs == '0)
            bs = ADDR_W'(1);
        if (bs > ADDR_W'(BLOCK_SIZE_MAX))
            bs = ADDR_W'(BLOCK_SIZE_MAX);
        return ADDR_W'(bno) * bs;
    endfunction

    function automatic void push_result(input logic [2:0] k, input int slot_idx,
                                        input logic [BNO_W-1:0] bno,
                                        input logic [ADDR_W-1:0] addr, input logic fin);
        result_t r;
        r.kind        = k;
        r.slot        = slot_t'(slot_idx);
        r.block_addr  = bno;
        r.mem_address = addr;
        r.last        = fin;
        pending_results.push_back(r);
    endfunction

    // One command: update the tag state and queue the memory requests it causes.
    function automatic void cache_step(input item_t it);
        int                 hit_idx;
        int                 victim;
        logic               found_empty;
        logic [STAMP_W-1:0] min_stamp;
        hit_idx = -1;
        if (it.action == ACT_FLUSH)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (dirty[i])
                begin
                    push_result(KIND_WB, i, tags[i], byte_address(tags[i]), 1'b0);
                    dirty[i] = 1'b0;
                end
            end
            push_result(KIND_DONE, 0, '0, '0, 1'b1);
        end
        else if (it.block_number == '0)
        begin
            push_result(KIND_REJECT, 0, '0, '0, 1'b1);
        end
        else
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
                if (hit_idx < 0 && tags[i] == it.block_number)
                    hit_idx = i;
            if (it.action == ACT_ACCESS)
            begin
                use_cnt = use_cnt + STAMP_W'(1);
                if (hit_idx >= 0)
                begin
                    stamps[hit_idx] = use_cnt;
                    dirty[hit_idx]  = dirty[hit_idx] | it.is_write;
                    push_result(KIND_HIT, hit_idx, it.block_number,
                                byte_address(it.block_number), 1'b1);
                end
                else
                begin
                    // first empty slot wins, else first slot with the oldest stamp
                    victim      = 0;
                    min_stamp   = stamps[0];
                    found_empty = 1'b0;
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        if (!found_empty)
                        begin
                            if (tags[i] == '0)
                            begin
                                victim      = i;
                                found_empty = 1'b1;
                            end
                            else if (stamps[i] < min_stamp)
                            begin
                                victim    = i;
                                min_stamp = stamps[i];
                            end
                        end
                    end
                    if (tags[victim] != '0 && dirty[victim])
                        push_result(KIND_WB, victim, tags[victim],
                                    byte_address(tags[victim]), 1'b0);
                    push_result(KIND_FILL, victim, it.block_number,
                                byte_address(it.block_number), 1'b1);
                    tags[victim]   = it.block_number;
                    stamps[victim] = use_cnt;
                    dirty[victim]  = it.is_write;
                end
            end
            else if (hit_idx < 0)
            begin
                push_result(KIND_ABSENT, 0, it.block_number, '0, 1'b1);
            end
            else if (it.action == ACT_MARK)
            begin
                dirty[hit_idx] = 1'b1;
                push_result(KIND_DONE, hit_idx, it.block_number, '0, 1'b1);
            end
            else if (dirty[hit_idx])
            begin
                push_result(KIND_WB, hit_idx, it.block_number,
                            byte_address(it.block_number), 1'b1);
                dirty[hit_idx] = 1'b0;
            end
            else
            begin
                push_result(KIND_DONE, hit_idx, it.block_number, '0, 1'b1);
            end
        end
    endfunction

    function automatic void note_mismatch(input string what, input result_t want,
                                          input result_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("%0t: %s: exp kind=%0d slot=%0d blk=%h addr=%h last=%0d",
                     $realtime, what, want.kind, want.slot, want.block_addr,
                     want.mem_address, want.last);
            $display("%0t: %s: got kind=%0d slot=%0d blk=%h addr=%h last=%0d",
                     $realtime, what, got.kind, got.slot, got.block_addr,
                     got.mem_address, got.last);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                tags[i]   = '0;
                stamps[i] = '0;
                dirty[i]  = 1'b0;
            end
            use_cnt    = '0;
            blk_size   = BLOCK_SIZE_RESET;
            mismatches = 0;
            pending_results.delete();
            open_cnt <= 0;
            errors   <= 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (pending_results.size() == 0)
                begin
                    note_mismatch("unexpected result", '0, result);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result.kind !== want.kind || result.slot !== want.slot ||
                        result.block_addr !== want.block_addr ||
                        result.mem_address !== want.mem_address ||
                        result.last !== want.last)
                        note_mismatch("result mismatch", want, result);
                end
            end
            if (cfg_valid && cfg_ready)
                blk_size = cfg_data;
            if (start && !busy)
                cache_step(item);
            open_cnt <= pending_results.size();
            errors   <= mismatches;
        end
    end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Top of the block cache control testbench: clock, reset, command and config stimulus.
// Depends on lwbc_pkg, the DUT and lwbc_checker, which does all prediction and checking.
module testbench;
    import lwbc_pkg::*;

    localparam int NUM_SLOTS    = NUM_SLOTS_DEF;
    localparam int DRAIN_CYCLES = 2 * NUM_SLOTS + 10;
    localparam int POOL_SIZE    = 24;
    localparam int PHASE_ITEMS  = 36;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            start     = 1'b0;
    logic            busy;
    item_t           item      = '0;
    result_t         result;
    logic            result_valid;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [BS_W-1:0] cfg_data  = '0;
    int              open_cnt;
    int              errors;

    // more hot blocks than slots keeps evictions going
    logic [BNO_W-1:0] hot_blocks [POOL_SIZE];
    bit               no_gaps;

    always #10 clk = ~clk;

    lru_write_back_block_cache_control #(
        .NUM_SLOTS(NUM_SLOTS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .result      (result),
        .result_valid(result_valid),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    lwbc_checker #(
        .NUM_SLOTS(NUM_SLOTS)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .result      (result),
        .result_valid(result_valid),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .open_cnt    (open_cnt),
        .errors      (errors)
    );

    function automatic logic [BNO_W-1:0] nonzero_block();
        logic [BNO_W-1:0] b;
        b = $urandom;
        if (b == '0)
            b = BNO_W'(1);
        return b;
    endfunction

    // Leaves start high after the transaction so back-to-back commands need no toggle.
    task automatic issue_cmd(input logic [1:0] act, input logic [BNO_W-1:0] bno,
                             input logic wr);
        int    gap;
        item_t it;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 15) == 0)
            no_gaps = !no_gaps;
        it.action       = act;
        it.block_number = bno;
        it.is_write     = wr;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        do @(posedge clk); while (busy);
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        do @(posedge clk); while (open_cnt != 0 || busy);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_block_size(input logic [BS_W-1:0] bs);
        wait_quiet();
        cfg_valid <= 1'b1;
        cfg_data  <= bs;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_cmd();
        int               sel;
        int               pick;
        logic [1:0]       act;
        logic [BNO_W-1:0] bno;
        sel  = $urandom_range(0, 99);
        pick = $urandom_range(0, 99);
        if (sel < 55)
            act = ACT_ACCESS;
        else if (sel < 70)
            act = ACT_MARK;
        else if (sel < 88)
            act = ACT_WB;
        else
            act = ACT_FLUSH;
        if (pick < 85)
            bno = hot_blocks[$urandom_range(0, POOL_SIZE - 1)];
        else if (pick < 95)
            bno = $urandom;
        else
            bno = '0;
        if ($urandom_range(0, 19) == 0)
            hot_blocks[$urandom_range(0, POOL_SIZE - 1)] = nonzero_block();
        issue_cmd(act, bno, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        logic [BS_W-1:0] size_plan [5];
        size_plan = '{17'd1, 17'd65536, 17'd0, 17'h1FFFF, 17'd512};
        size_plan[4] = BS_W'($urandom_range(2, 65535));
        hot_blocks[0] = 32'd1;
        hot_blocks[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            hot_blocks[i] = nonzero_block();
        no_gaps = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pass at the reset block size
        issue_cmd(ACT_ACCESS, 32'd1, 1'b1);
        issue_cmd(ACT_ACCESS, 32'hFFFF_FFFF, 1'b0);
        issue_cmd(ACT_ACCESS, 32'd1, 1'b0);
        issue_cmd(ACT_ACCESS, '0, 1'b1);
        issue_cmd(ACT_MARK, '0, 1'b0);
        issue_cmd(ACT_WB, '0, 1'b1);
        issue_cmd(ACT_MARK, 32'h1234_5678, 1'b0);
        issue_cmd(ACT_WB, 32'h1234_5678, 1'b1);
        issue_cmd(ACT_MARK, 32'hFFFF_FFFF, 1'b0);
        issue_cmd(ACT_WB, 32'hFFFF_FFFF, 1'b0);
        issue_cmd(ACT_WB, 32'hFFFF_FFFF, 1'b0);
        issue_cmd(ACT_FLUSH, 32'hFFFF_FFFF, 1'b1);
        // fill the slots left empty, then force LRU evictions with the last two accesses
        for (int b = 2; b <= NUM_SLOTS + 1; b++)
            issue_cmd(ACT_ACCESS, BNO_W'(b), !b[0]);

        foreach (size_plan[p])
        begin
            set_block_size(size_plan[p]);
            repeat (PHASE_ITEMS) random_cmd();
        end

        wait_quiet();
        if (errors == 0)
            $display("** lru_write_back_block_cache_control: PASSED **");
        else
            $display("** lru_write_back_block_cache_control: FAILED **");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("** lru_write_back_block_cache_control: FAILED **");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/lwbc_pkg.sv
rtl/lwbc_cell.sv
rtl/lwbc_result.sv
rtl/lru_write_back_block_cache_control.sv
verif/lwbc_checker.sv
verif/testbench.sv
